### hdl/cljd_pkg.sv
`default_nettype none

package cljd_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CONN_W      = 8;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int OUTCOME_W = 2;
  localparam int TIME_W    = 63;
  localparam int MAXRUN_W  = 5;
  localparam int BUDGET_W  = 11;
  localparam int ERR_W     = 2;

  // Stream and configuration widths
  localparam int IN_BITS    = CONN_W + IDX_W + OUTCOME_W + TIME_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + IDX_W + CONN_W + IDX_W + 1 + ERR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_W;

  // Register reset values
  localparam logic [MAXRUN_W-1:0] MAXRUN_RST = MAXRUN_W'(4);
  localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_ABORT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_RUNNING = 3'd2,
    ST_DONE    = 3'd3,
    ST_FAILED  = 3'd4,
    ST_ABORTED = 3'd5
  } job_state_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_OK      = 2'd0,
    OUT_ABORTED = 2'd1,
    OUT_FAILED  = 2'd2
  } outcome_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_SLOT = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RUN = 2'd0,
    REG_BUDGET  = 2'd1,
    REG_START   = 2'd2,
    REG_STOP    = 2'd3
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the accepted word and the table lookups
    logic exec;  // apply the command and load the result register
  } cljd_ctl_t;

endpackage

`default_nettype wire

### hdl/cljd_ctrl.sv
`default_nettype none

module cljd_ctrl
  import cljd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output cljd_ctl_t      ctl
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  // Take a word only between items; the result register sits apart
  assign s_tready = (state == IDLE);
  assign ctl.load = s_tvalid && s_tready;
  assign ctl.exec = (state == EXEC) && (!m_tvalid || m_tready);

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (ctl.load) state <= EXEC;
        end
        EXEC: begin
          if (ctl.exec) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (ctl.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/cljd_datapath.sv
`default_nettype none

module cljd_datapath
  import cljd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cljd_ctl_t             ctl,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [CMD_W-1:0]      s_tuser,
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [MAXRUN_W-1:0] max_running_jobs;
  logic [BUDGET_W-1:0] total_connection_budget;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   stop_time;

  // Table and counters
  job_state_t          job_status [TABLE_DEPTH];
  logic [CONN_W-1:0]   conn_mem   [TABLE_DEPTH];
  logic [CNT_W-1:0]    job_count;
  logic [BUDGET_W-1:0] connections_in_use;
  logic [CNT_W-1:0]    running_count;
  logic                abort_flag;
  logic                halted_flag;

  // Captured item
  cmd_t                cmd;
  logic [CONN_W-1:0]   need;
  logic [IDX_W-1:0]    slot;
  logic [OUTCOME_W-1:0] outcome;
  logic                before_start;
  logic                past_stop;
  logic [IDX_W-1:0]    first_queued;
  logic                any_queued;
  logic                any_live;
  logic [CONN_W-1:0]   conn_rd;

  // Input field slices
  logic [CONN_W-1:0]    in_need;
  logic [IDX_W-1:0]     in_slot;
  logic [OUTCOME_W-1:0] in_outcome;
  logic [TIME_W-1:0]    in_now;

  assign in_need    = s_tdata[CONN_W-1:0];
  assign in_slot    = s_tdata[CONN_W +: IDX_W];
  assign in_outcome = s_tdata[CONN_W+IDX_W +: OUTCOME_W];
  assign in_now     = s_tdata[CONN_W+IDX_W+OUTCOME_W +: TIME_W];

  // Scan the table for the first queued slot and any live job
  logic [IDX_W-1:0] scan_idx;
  logic             scan_queued;
  logic             scan_live;

  always_comb begin
    scan_idx    = '0;
    scan_queued = 1'b0;
    scan_live   = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (job_status[i] == ST_QUEUED) begin
        scan_idx    = IDX_W'(i);
        scan_queued = 1'b1;
      end
      if (job_status[i] == ST_QUEUED || job_status[i] == ST_RUNNING) scan_live = 1'b1;
    end
  end

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_running_jobs        <= MAXRUN_RST;
      total_connection_budget <= BUDGET_RST;
      start_time              <= '0;
      stop_time               <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RUN: max_running_jobs        <= cfg_data[MAXRUN_W-1:0];
        REG_BUDGET:  total_connection_budget <= cfg_data[BUDGET_W-1:0];
        REG_START:   start_time              <= cfg_data[TIME_W-1:0];
        REG_STOP:    stop_time               <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the word, the time checks and the table lookups
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd          <= cmd_t'(s_tuser);
      need         <= in_need;
      slot         <= in_slot;
      outcome      <= in_outcome;
      before_start <= (start_time != '0) && (in_now < start_time);
      past_stop    <= (stop_time != '0) && (in_now >= stop_time);
      first_queued <= scan_idx;
      any_queued   <= scan_queued;
      any_live     <= scan_live;
    end
  end

  // Decide the command's effect
  logic                grant;
  logic                halt_set;
  logic                enq_ok;
  logic                comp_ok;
  err_t                err;
  logic [CONN_W-1:0]   need_eff;
  logic [CONN_W-1:0]   in_need_eff;
  logic [BUDGET_W-1:0] budget_left;
  logic [CONN_W-1:0]   use_conn;
  logic [BUDGET_W-1:0] back;
  job_state_t          done_state;

  always_comb begin
    grant       = 1'b0;
    halt_set    = 1'b0;
    enq_ok      = 1'b0;
    comp_ok     = 1'b0;
    err         = ERR_NONE;
    need_eff    = (conn_rd == '0) ? CONN_W'(1) : conn_rd;
    in_need_eff = (need == '0) ? CONN_W'(1) : need;
    budget_left = total_connection_budget - connections_in_use;
    use_conn    = (BUDGET_W'(need_eff) <= budget_left) ? need_eff : budget_left[CONN_W-1:0];
    back        = BUDGET_W'(conn_rd);
    unique case (outcome_t'(outcome))
      OUT_OK:      done_state = ST_DONE;
      OUT_ABORTED: done_state = ST_ABORTED;
      default:     done_state = ST_FAILED;
    endcase
    unique case (cmd)
      CMD_ENQUEUE: begin
        if (job_count == CNT_W'(TABLE_DEPTH)) err = ERR_FULL;
        else enq_ok = 1'b1;
      end
      CMD_DISPATCH: begin
        priority if (halted_flag) begin
        end else if (abort_flag) begin
          halt_set = 1'b1;
        end else if (before_start) begin
        end else if (!any_live) begin
          halt_set = 1'b1;
        end else if (past_stop) begin
          halt_set = (running_count == '0);
        end else if (running_count >= max_running_jobs) begin
        end else if (total_connection_budget <= connections_in_use) begin
        end else begin
          grant = any_queued;
        end
      end
      CMD_COMPLETE: begin
        if (job_status[slot] != ST_RUNNING) err = ERR_SLOT;
        else comp_ok = 1'b1;
      end
      CMD_ABORT: halt_set = 1'b1;
      default: ;
    endcase
  end

  // Apply the command to the table and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) job_status[i] <= ST_EMPTY;
      job_count          <= '0;
      connections_in_use <= '0;
      running_count      <= '0;
      abort_flag         <= 1'b0;
      halted_flag        <= 1'b0;
    end else if (ctl.exec) begin
      if (enq_ok) begin
        job_status[job_count[IDX_W-1:0]] <= ST_QUEUED;
        job_count <= job_count + CNT_W'(1);
      end
      if (grant) begin
        job_status[first_queued] <= ST_RUNNING;
        connections_in_use <= connections_in_use + BUDGET_W'(use_conn);
        running_count      <= running_count + CNT_W'(1);
      end
      if (comp_ok) begin
        job_status[slot] <= done_state;
        connections_in_use <= (back >= connections_in_use) ? '0 : connections_in_use - back;
        if (running_count != '0) running_count <= running_count - CNT_W'(1);
      end
      if (cmd == CMD_ABORT) abort_flag <= 1'b1;
      if (halt_set) halted_flag <= 1'b1;
    end
  end

  // Connection memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.exec && enq_ok) begin
      conn_mem[job_count[IDX_W-1:0]] <= in_need_eff;
    end else if (ctl.exec && grant) begin
      conn_mem[first_queued] <= use_conn;
    end
    if (ctl.load) begin
      conn_rd <= (cmd_t'(s_tuser) == CMD_COMPLETE) ? conn_mem[in_slot] : conn_mem[scan_idx];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      m_tdata <= OUT_DATA_W'({
        err,
        halted_flag | halt_set,
        enq_ok ? job_count[IDX_W-1:0] : IDX_W'(0),
        grant ? use_conn : CONN_W'(0),
        grant ? first_queued : IDX_W'(0),
        grant
      });
    end
  end

endmodule

`default_nettype wire

### hdl/credit_limited_job_dispatcher_unit.sv
// Each accepted item is captured, then executed into the result register once that register is free.
// The controller takes one item at a time: no new word is accepted until the last one is executed.
// A waiting result sits in an output register, so the next word is accepted meanwhile.
// Reset (rst, synchronous): table empty, counters and flags clear, registers to
// max_running_jobs 4, budget 16, start and stop times 0.
`default_nettype none

module credit_limited_job_dispatcher_unit
  import cljd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // need_connections, slot_index, outcome, now_time
  input  wire logic [CMD_W-1:0]      s_tuser,  // cmd
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // grant_valid, grant_slot, grant_connections, enqueue_slot, finished, error
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cljd_ctl_t ctl;

  cljd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  cljd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### hdl/cljd_checker.sv
`default_nettype none

module cljd_checker
  import cljd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // One item at a time: no word right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in execution");

  // A new result appears only out of the execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised without an executed item");

  // A grant never carries an error
  a_grant_no_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[19:18] == 2'd0)
    else $error("grant reported together with an error");

  // Without a grant, slot and connection fields are zero
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == 12'd0)
    else $error("grant fields set without a grant");

endmodule

bind credit_limited_job_dispatcher_unit cljd_checker u_cljd_checker (.*);

`default_nettype wire

### sim/tb_credit_limited_job_dispatcher_unit.sv
`timescale 1ns / 1ps

module tb_credit_limited_job_dispatcher_unit;
  import cljd_pkg::*;

  localparam int RST_CYCLES     = 11;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int STALL_CYCLES   = 300;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One result word, first field in the highest bits
  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic              finished;
    logic [IDX_W-1:0]  enq_slot;
    logic [CONN_W-1:0] grant_conn;
    logic [IDX_W-1:0]  grant_slot;
    logic              grant_valid;
  } result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = CMD_ENQUEUE;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_RUN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  credit_limited_job_dispatcher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Dispatcher mirror: job table, counters, flags and registers
  job_state_t        slot_state [TABLE_DEPTH];
  logic [CONN_W-1:0] slot_conn  [TABLE_DEPTH];
  int unsigned       slots_used   = 0;
  int unsigned       running_jobs = 0;
  logic [BUDGET_W-1:0] conn_in_use = '0;
  bit                abort_seen = 1'b0;
  bit                halted     = 1'b0;
  logic [MAXRUN_W-1:0] run_limit   = MAXRUN_RST;
  logic [BUDGET_W-1:0] conn_budget = BUDGET_RST;
  logic [TIME_W-1:0]   t_start     = '0;
  logic [TIME_W-1:0]   t_stop      = '0;

  result_t results_due [$];
  int      mismatches    = 0;
  int      src_idle_pct  = 7;
  int      sink_idle_pct = 80;
  int      stall_req     = 0;
  int      stall_ack     = 0;
  int      stall_left    = 0;
  int      idle_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic bit any_live();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_state[i] == ST_QUEUED || slot_state[i] == ST_RUNNING) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Pick one running slot at random, -1 when none runs
  function automatic int any_running_slot();
    int found [$];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_state[i] == ST_RUNNING) found.insert(found.size(), i);
    end
    if (found.size() == 0) return -1;
    return found[$urandom_range(found.size() - 1)];
  endfunction

  // Dispatch attempt: hold, halt, or grant the first queued slot
  function automatic result_t dispatch_job(input logic [TIME_W-1:0] now);
    result_t     r;
    int unsigned room;
    int unsigned take;
    r = '0;
    if (halted) return r;
    if (abort_seen) begin
      halted = 1'b1;
      return r;
    end
    if (t_start != 0 && now < t_start) return r;
    if (!any_live()) begin
      halted = 1'b1;
      return r;
    end
    if (t_stop != 0 && now >= t_stop) begin
      if (running_jobs == 0) halted = 1'b1;
      return r;
    end
    if (running_jobs >= run_limit) return r;
    if (conn_budget <= conn_in_use) return r;
    room = conn_budget - conn_in_use;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_state[i] == ST_QUEUED) begin
        take = (slot_conn[i] <= room) ? slot_conn[i] : room;
        slot_conn[i]  = take[CONN_W-1:0];
        slot_state[i] = ST_RUNNING;
        conn_in_use   = conn_in_use + take[BUDGET_W-1:0];
        running_jobs++;
        r.grant_valid = 1'b1;
        r.grant_slot  = i[IDX_W-1:0];
        r.grant_conn  = take[CONN_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // Apply one accepted word to the mirror and return the result it causes
  function automatic result_t job_table_step(input cmd_t cmd, input logic [CONN_W-1:0] need,
                                             input logic [IDX_W-1:0] slot,
                                             input logic [OUTCOME_W-1:0] outcome,
                                             input logic [TIME_W-1:0] now);
    result_t r;
    r = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (slots_used >= TABLE_DEPTH) begin
          r.err = ERR_FULL;
        end else begin
          slot_state[slots_used] = ST_QUEUED;
          slot_conn[slots_used]  = (need == 0) ? CONN_W'(1) : need;
          r.enq_slot = slots_used[IDX_W-1:0];
          slots_used++;
        end
      end
      CMD_DISPATCH: begin
        r = dispatch_job(now);
      end
      CMD_COMPLETE: begin
        if (slot_state[slot] != ST_RUNNING) begin
          r.err = ERR_SLOT;
        end else begin
          // unknown outcome counts as failed
          slot_state[slot] = (outcome == OUT_OK) ? ST_DONE :
                             (outcome == OUT_ABORTED) ? ST_ABORTED : ST_FAILED;
          conn_in_use = (slot_conn[slot] >= conn_in_use) ? '0 : conn_in_use - slot_conn[slot];
          if (running_jobs > 0) running_jobs--;
        end
      end
      default: begin
        abort_seen = 1'b1;
        halted     = 1'b1;
      end
    endcase
    r.finished = halted;
    return r;
  endfunction

  // Offer one word, wait for acceptance, then log its result
  task automatic send_word(input cmd_t cmd, input logic [CONN_W-1:0] need,
                           input logic [IDX_W-1:0] slot, input logic [OUTCOME_W-1:0] outcome,
                           input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_W'({now, outcome, slot, need});
    do @(posedge clk); while (!s_tready);
    results_due.insert(results_due.size(), job_table_step(cmd, need, slot, outcome, now));
    @(negedge clk);
  endtask

  task automatic enqueue(input logic [CONN_W-1:0] need);
    send_word(CMD_ENQUEUE, need, IDX_W'($urandom), OUTCOME_W'($urandom), rand_time());
  endtask

  task automatic dispatch(input logic [TIME_W-1:0] now);
    send_word(CMD_DISPATCH, CONN_W'($urandom), IDX_W'($urandom), OUTCOME_W'($urandom), now);
  endtask

  task automatic complete(input logic [IDX_W-1:0] slot, input logic [OUTCOME_W-1:0] outcome);
    send_word(CMD_COMPLETE, CONN_W'($urandom), slot, outcome, rand_time());
  endtask

  task automatic abort_all();
    send_word(CMD_ABORT, CONN_W'($urandom), IDX_W'($urandom), OUTCOME_W'($urandom),
              rand_time());
  endtask

  // Drop valid, wait for every result, then let the pipeline go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_MAX_RUN: run_limit   = val[MAXRUN_W-1:0];
      REG_BUDGET:  conn_budget = val[BUDGET_W-1:0];
      REG_START:   t_start     = val[TIME_W-1:0];
      default:     t_stop      = val[TIME_W-1:0];
    endcase
  endtask

  // Random word that keeps the dispatcher from halting
  task automatic random_item();
    int unsigned       pick;
    int                busy;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(99);
    busy = any_running_slot();
    case ($urandom_range(3))
      0:       now = rand_time();
      1:       now = t_start + TIME_W'($urandom_range(4)) - TIME_W'(2);
      2:       now = t_stop + TIME_W'($urandom_range(4)) - TIME_W'(2);
      default: now = TIME_W'($urandom_range(4000));
    endcase
    if (pick < 6 || (pick >= 36 && !any_live())) begin
      enqueue($urandom_range(1) ? CONN_W'($urandom_range(20)) : CONN_W'($urandom));
    end else if (pick < 36) begin
      complete((busy >= 0 && $urandom_range(3) != 0) ? IDX_W'(busy) : IDX_W'($urandom),
               OUTCOME_W'($urandom));
    end else begin
      // step back from the stop time when nothing runs, else the block drains for good
      if (t_stop != 0 && now >= t_stop && running_jobs == 0) now = t_stop - TIME_W'(1);
      dispatch(now);
    end
  endtask

  task automatic test_enqueue();
    enqueue(8'd0);
    enqueue(8'd255);
    enqueue(8'd1);
    enqueue(8'd128);
    settle();
  endtask

  task automatic test_start_hold();
    write_reg(REG_START, 1000);
    dispatch(0);
    dispatch(999);
    dispatch(1000);
    settle();
  endtask

  task automatic test_partial_grant();
    dispatch(1500);
    dispatch(1500);
    settle();
    write_reg(REG_BUDGET, 0);
    dispatch(2000);
    settle();
    write_reg(REG_BUDGET, 2047);
    dispatch(2000);
    settle();
  endtask

  task automatic test_run_limit();
    write_reg(REG_MAX_RUN, 3);
    dispatch(2500);
    settle();
    write_reg(REG_MAX_RUN, 0);
    dispatch(2500);
    settle();
    write_reg(REG_MAX_RUN, 31);
    dispatch(2500);
    settle();
  endtask

  task automatic test_completion();
    complete(5, OUT_OK);
    enqueue(8'd7);
    complete(4, OUT_OK);
    complete(0, OUT_OK);
    complete(0, OUT_OK);
    complete(1, OUT_ABORTED);
    complete(2, 2'd3);
    settle();
  endtask

  task automatic test_stop_drain();
    write_reg(REG_STOP, 5000);
    dispatch(5000);
    dispatch(TIME_MAX);
    dispatch(4999);
    settle();
  endtask

  task automatic test_time_extremes();
    write_reg(REG_START, TIME_MAX);
    write_reg(REG_STOP, 0);
    enqueue(8'd200);
    dispatch(TIME_MAX - TIME_W'(1));
    dispatch(TIME_MAX);
    settle();
    write_reg(REG_START, 0);
    write_reg(REG_STOP, TIME_MAX);
    dispatch(0);
    settle();
  endtask

  // Random words in chunks, with fresh register settings between chunks
  task automatic test_random_traffic(input int items, input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 50 == 0) begin
        settle();
        write_reg(REG_MAX_RUN, ($urandom_range(15) == 0) ? CFG_DATA_W'(0) :
                               CFG_DATA_W'($urandom_range(1, 16)));
        write_reg(REG_BUDGET, CFG_DATA_W'($urandom_range(1, 400)));
        write_reg(REG_START, $urandom_range(1) ? CFG_DATA_W'(0) :
                             CFG_DATA_W'($urandom_range(1, 3000)));
        write_reg(REG_STOP, ($urandom_range(2) == 0) ? CFG_DATA_W'($urandom_range(2000, 6000)) :
                            CFG_DATA_W'(0));
      end
      random_item();
    end
    settle();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_req++;
    repeat (24) random_item();
    settle();
  endtask

  // Fill the table, then halt by drain, stop time or abort
  task automatic test_halt();
    int unsigned mode;
    int          busy;
    mode = $urandom_range(2);
    write_reg(REG_MAX_RUN, 16);
    write_reg(REG_BUDGET, 2047);
    write_reg(REG_START, 0);
    write_reg(REG_STOP, 0);
    while (slots_used < TABLE_DEPTH) enqueue(CONN_W'($urandom));
    enqueue(8'd9);
    if (mode == 2) abort_all();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_state[i] == ST_RUNNING) complete(IDX_W'(i), OUTCOME_W'($urandom));
    end
    if (mode == 1 && any_live()) begin
      settle();
      write_reg(REG_STOP, 100);
      dispatch(100);
    end
    while (!halted) begin
      busy = any_running_slot();
      if (busy >= 0) begin
        complete(IDX_W'(busy), OUTCOME_W'($urandom));
      end else begin
        dispatch(TIME_W'($urandom_range(99)));
      end
    end
    // table still acts after the halt
    dispatch(rand_time());
    enqueue(8'hFF);
    complete(IDX_W'($urandom), OUTCOME_W'($urandom));
    abort_all();
    dispatch(rand_time());
    settle();
  endtask

  // Receiver ready: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= STALL_CYCLES;
      m_tready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("grant_valid", want.grant_valid, got.grant_valid);
        check_field("grant_slot", want.grant_slot, got.grant_slot);
        check_field("grant_connections", want.grant_conn, got.grant_conn);
        check_field("enqueue_slot", want.enq_slot, got.enq_slot);
        check_field("finished", want.finished, got.finished);
        check_field("error", want.err, got.err);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_conn[i]  = '0;
    end
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_enqueue();
    test_start_hold();
    test_partial_grant();
    test_run_limit();
    test_completion();
    test_stop_drain();
    test_time_extremes();
    test_random_traffic(120, 7, 80);
    test_random_traffic(120, 80, 7);
    test_random_traffic(120, 0, 0);
    test_backpressure();
    test_halt();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
